// ----- rtl/orf_pkg.sv -----
// ----------------------------------------------------------------------------
// orf_pkg: shared types and constants for the overwriting ring fifo
// Command codes, controller states, control struct and port widths.
// ----------------------------------------------------------------------------
package orf_pkg;

  // payload and register widths
  localparam int unsigned CmdW     = 2;
  localparam int unsigned DataW    = 32;
  localparam int unsigned LenW     = 6;
  localparam int unsigned CapW     = 7;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // capacity register value after reset
  localparam logic [CapW-1:0] CapReset = 7'd64;

  // register index taken from the word-aligned address bit
  localparam logic RegCapacity = 1'b0;

  // queue commands
  typedef enum logic [CmdW-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_CLR  = 2'd2,
    CMD_STAT = 2'd3
  } cmd_e;

  // controller states: which of pending stage and output register hold data
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PEND = 2'd1,
    ST_OUT  = 2'd2,
    ST_BOTH = 2'd3
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic load_out;
  } ctrl_cmd_t;

endpackage

// ----- rtl/orf_in_if.sv -----
// ----------------------------------------------------------------------------
// orf_in_if: request channel
// Valid/ready channel carrying one queue command and its element.
// ----------------------------------------------------------------------------
interface orf_in_if;
  logic                        valid;
  logic                        ready;
  logic [orf_pkg::CmdW-1:0]    command;
  logic [orf_pkg::DataW-1:0]   data_in;

  modport source (output valid, output command, output data_in, input ready);
  modport sink   (input valid, input command, input data_in, output ready);
endinterface

// ----- rtl/orf_out_if.sv -----
// ----------------------------------------------------------------------------
// orf_out_if: response channel
// Valid/ready channel carrying the element read and the queue status.
// ----------------------------------------------------------------------------
interface orf_out_if;
  logic                        valid;
  logic                        ready;
  logic [orf_pkg::DataW-1:0]   data_out;
  logic                        ok;
  logic                        is_empty;
  logic                        is_full;
  logic [orf_pkg::LenW-1:0]    length;

  modport source (output valid, output data_out, output ok, output is_empty,
                  output is_full, output length, input ready);
  modport sink   (input valid, input data_out, input ok, input is_empty,
                  input is_full, input length, output ready);
endinterface

// ----- rtl/orf_ram.sv -----
// ----------------------------------------------------------------------------
// orf_ram: generic single-port-write, single-port-read ram
// One write and one registered read per cycle, no reset on contents.
// ----------------------------------------------------------------------------
module orf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/orf_ctrl.sv -----
// ----------------------------------------------------------------------------
// orf_ctrl: transaction flow controller
// Tracks the pending stage and output register, drives ready and valid.
// ----------------------------------------------------------------------------
module orf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output orf_pkg::ctrl_cmd_t cmd_o
);

  orf_pkg::state_e state_q, state_d;
  logic            acc;
  logic            take;

  // handshake events
  assign acc  = in_valid_i && (state_q != orf_pkg::ST_BOTH);
  assign take = out_ready_i && ((state_q == orf_pkg::ST_OUT) ||
                                (state_q == orf_pkg::ST_BOTH));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      orf_pkg::ST_IDLE: begin
        state_d = acc ? orf_pkg::ST_PEND : orf_pkg::ST_IDLE;
      end
      orf_pkg::ST_PEND: begin
        state_d = acc ? orf_pkg::ST_BOTH : orf_pkg::ST_OUT;
      end
      orf_pkg::ST_OUT: begin
        if (take) begin
          state_d = acc ? orf_pkg::ST_PEND : orf_pkg::ST_IDLE;
        end else begin
          state_d = acc ? orf_pkg::ST_BOTH : orf_pkg::ST_OUT;
        end
      end
      orf_pkg::ST_BOTH: begin
        state_d = take ? orf_pkg::ST_OUT : orf_pkg::ST_BOTH;
      end
      default: state_d = orf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = (state_q != orf_pkg::ST_BOTH);
    out_valid_o    = 1'b0;
    cmd_o.accept   = acc;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      orf_pkg::ST_IDLE: begin
      end
      orf_pkg::ST_PEND: begin
        cmd_o.load_out = 1'b1;
      end
      orf_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
      end
      orf_pkg::ST_BOTH: begin
        out_valid_o    = 1'b1;
        cmd_o.load_out = take;
      end
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= orf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/orf_datapath.sv -----
// ----------------------------------------------------------------------------
// orf_datapath: ring pointers, fill count, slot ram and result registers
// Updates the queue on each accepted transaction and builds its response.
// ----------------------------------------------------------------------------
module orf_datapath #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned ELEM_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  orf_pkg::ctrl_cmd_t          cmd_i,
  input  logic                        cfg_wr_i,
  input  logic [orf_pkg::CapW-1:0]    cap_i,
  input  logic [orf_pkg::CmdW-1:0]    command_i,
  input  logic [orf_pkg::DataW-1:0]   data_in_i,
  output logic [orf_pkg::DataW-1:0]   data_out_o,
  output logic                        ok_o,
  output logic                        is_empty_o,
  output logic                        is_full_o,
  output logic [orf_pkg::LenW-1:0]    length_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (NW > orf_pkg::CapW) ? NW : orf_pkg::CapW;

  logic [PW-1:0]        head_q, head_d, tail_q, tail_d;
  logic [NW-1:0]        cnt_q, cnt_d;
  logic [NW-1:0]        ring_n, ring_last;
  logic [CW-1:0]        cap_ext;
  logic                 full_now, empty_now;
  logic                 deq_hit, ok_now;
  orf_pkg::cmd_e        cmd;
  logic [ELEM_BITS-1:0] rdata;
  logic                 ram_we;

  // pending stage
  logic                      s1_deq_q, s1_ok_q, s1_empty_q, s1_full_q;
  logic [orf_pkg::LenW-1:0]  s1_len_q;

  // output register
  logic [orf_pkg::DataW-1:0] data_out_q;
  logic                      ok_q, empty_q, full_q;
  logic [orf_pkg::LenW-1:0]  len_q;

  // step one pointer with wrap at the ring size
  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [NW-1:0] last);
    logic [PW-1:0] r;
    r = (NW'(p) == last) ? '0 : p + PW'(1);
    return r;
  endfunction

  // ring size clamped to 2..DEPTH
  assign cap_ext = CW'(cap_i);
  always_comb begin
    if (cap_i < orf_pkg::CapW'(2)) begin
      ring_n = NW'(2);
    end else if (cap_ext > CW'(DEPTH)) begin
      ring_n = NW'(DEPTH);
    end else begin
      ring_n = NW'(cap_i);
    end
  end
  assign ring_last = ring_n - NW'(1);

  assign cmd       = orf_pkg::cmd_e'(command_i);
  assign full_now  = (cnt_q == ring_last);
  assign empty_now = (cnt_q == '0);

  // queue update for one transaction
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    deq_hit = 1'b0;
    ok_now  = 1'b1;
    if (cmd_i.accept) begin
      unique case (cmd)
        orf_pkg::CMD_ENQ: begin
          // full queue drops its oldest entry
          if (full_now) begin
            head_d = adv(head_q, ring_last);
          end else begin
            cnt_d = cnt_q + NW'(1);
          end
          tail_d = adv(tail_q, ring_last);
        end
        orf_pkg::CMD_DEQ: begin
          if (empty_now) begin
            ok_now = 1'b0;
          end else begin
            deq_hit = 1'b1;
            head_d  = adv(head_q, ring_last);
            cnt_d   = cnt_q - NW'(1);
          end
        end
        orf_pkg::CMD_CLR: begin
          head_d = '0;
          tail_d = '0;
          cnt_d  = '0;
        end
        orf_pkg::CMD_STAT: begin
        end
        default: begin
        end
      endcase
    end
    // capacity write empties the queue
    if (cfg_wr_i) begin
      head_d = '0;
      tail_d = '0;
      cnt_d  = '0;
    end
  end

  // pointer and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // slot storage, head slot read on every accepted transaction
  assign ram_we = cmd_i.accept && (cmd == orf_pkg::CMD_ENQ);

  orf_ram #(
    .Width (ELEM_BITS),
    .Depth (DEPTH)
  ) u_orf_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ELEM_BITS'(data_in_i)),
    .re_i    (cmd_i.accept),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  // pending stage, status after the transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s1_deq_q   <= deq_hit;
      s1_ok_q    <= ok_now;
      s1_empty_q <= (cnt_d == '0);
      s1_full_q  <= (cnt_d == ring_last);
      s1_len_q   <= orf_pkg::LenW'(cnt_d);
    end
  end

  // output register, read data joins the status here
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      data_out_q <= s1_deq_q ? orf_pkg::DataW'(rdata) : '0;
      ok_q       <= s1_ok_q;
      empty_q    <= s1_empty_q;
      full_q     <= s1_full_q;
      len_q      <= s1_len_q;
    end
  end

  assign data_out_o = data_out_q;
  assign ok_o       = ok_q;
  assign is_empty_o = empty_q;
  assign is_full_o  = full_q;
  assign length_o   = len_q;

endmodule

// ----- rtl/overwriting_ring_fifo_core.sv -----
// ----------------------------------------------------------------------------
// overwriting_ring_fifo_core: ring fifo whose enqueue overwrites the oldest
//
// Requests arrive on req_i (command, data_in) and every request gives exactly
// one response on rsp_o (data_out, ok, is_empty, is_full, length), in order.
// Commands: enqueue (drops the oldest entry when full), dequeue (ok low and
// zero data when empty), clear, and status query. At most capacity-1 entries
// are held, with capacity clamped to 2..DEPTH. The capacity register sits at
// APB address 0; writing it empties the queue. The user must write it only
// while no transaction is in flight; the block does not enforce this.
// A response turns valid once its request has passed the registered slot ram
// read and pending stage and then the output register.
// With a ready receiver a request can be accepted while the previous one is
// in the single pending stage in front of the output register.
// A stalled receiver holds the response; one more request is accepted into
// the pending stage, after which req_i.ready drops.
// Reset clears pointers, fill count, handshake state and sets capacity to 64;
// slot contents are not cleared; only written slots supply read data.
// ----------------------------------------------------------------------------
module overwriting_ring_fifo_core #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned ELEM_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  orf_in_if.sink                        req_i,
  orf_out_if.source                     rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [orf_pkg::ApbAddrW-1:0]  paddr,
  input  logic [orf_pkg::ApbDataW-1:0]  pwdata,
  output logic [orf_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  orf_pkg::ctrl_cmd_t        cmd;
  logic                      cfg_wr;
  logic [orf_pkg::CapW-1:0]  cap_q;
  logic                      cap_sel;

  // register port, capacity only
  assign pready  = 1'b1;
  assign cap_sel = (paddr[orf_pkg::ApbAddrW-1] == orf_pkg::RegCapacity);
  assign cfg_wr  = psel && penable && pwrite && pready && cap_sel;
  assign prdata  = cap_sel ? orf_pkg::ApbDataW'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= orf_pkg::CapReset;
    end else if (cfg_wr) begin
      cap_q <= pwdata[orf_pkg::CapW-1:0];
    end
  end

  // flow controller
  orf_ctrl u_orf_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // queue datapath
  orf_datapath #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_orf_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_wr_i   (cfg_wr),
    .cap_i      (cap_q),
    .command_i  (req_i.command),
    .data_in_i  (req_i.data_in),
    .data_out_o (rsp_o.data_out),
    .ok_o       (rsp_o.ok),
    .is_empty_o (rsp_o.is_empty),
    .is_full_o  (rsp_o.is_full),
    .length_o   (rsp_o.length)
  );

endmodule

// ----- rtl/orf_checker.sv -----
// ----------------------------------------------------------------------------
// orf_checker: port-level checks for the overwriting ring fifo
// Watches the response channel and its status fields over time.
// ----------------------------------------------------------------------------
module orf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [orf_pkg::DataW-1:0]   data_out_i,
  input logic                        ok_i,
  input logic                        is_empty_i,
  input logic                        is_full_i,
  input logic [orf_pkg::LenW-1:0]    length_i
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({data_out_i, ok_i, is_empty_i, is_full_i, length_i}))
    else $error("response changed while stalled");

  // failed dequeue only on an empty queue, with zero data
  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ok_i |-> (data_out_i == '0) && is_empty_i)
    else $error("failed transaction with data or non-empty queue");

  // empty queue reports zero length and not full
  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_empty_i |-> (length_i == '0) && !is_full_i)
    else $error("empty status inconsistent with length or full");

  // full queue is never empty and never a failed dequeue
  a_full_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_full_i |-> ok_i && !is_empty_i)
    else $error("full status inconsistent");

endmodule

bind overwriting_ring_fifo_core orf_checker u_orf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .data_out_i  (rsp_o.data_out),
  .ok_i        (rsp_o.ok),
  .is_empty_i  (rsp_o.is_empty),
  .is_full_i   (rsp_o.is_full),
  .length_i    (rsp_o.length)
);
